### design/symbol_table_lookup_relocate_defines.svh
// Assertion macros shared by the symbol table modules.
// Each macro expects signals named clock and reset in the using module.
`ifndef SYMBOL_TABLE_LOOKUP_RELOCATE_DEFINES_SVH
`define SYMBOL_TABLE_LOOKUP_RELOCATE_DEFINES_SVH

// Same-cycle implication.
`define STLR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stlr: same-cycle check failed");

// Next-cycle implication.
`define STLR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stlr: next-cycle check failed");

`endif

### design/stlr_pkg.sv
package stlr_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int NAME_WORDS  = 4;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = IDX_W + 1;
   localparam int WORD_W  = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
   localparam int NADDR_W = $clog2(TABLE_DEPTH * NAME_WORDS);

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [NADDR_W-1:0] naddr_type;

   localparam word_type WORD_LAST = word_type'(NAME_WORDS - 1);

   localparam logic [15:0] ADDR_OFFSET_RESET = 16'd100;

   typedef enum logic [2:0] {
      FUNC_STAGE    = 3'd0,
      FUNC_ADD      = 3'd1,
      FUNC_FIND_SYM = 3'd2,
      FUNC_FIND_MAC = 3'd3,
      FUNC_RELOC    = 3'd4
   } func_type;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_MACRO = 2'd1;

   typedef struct packed {
      logic [2:0]         func;
      logic [63:0]        name_chunk;
      logic [1:0]         chunk_index;
      logic signed [31:0] value;
      logic [1:0]         symbol_kind;
      logic [15:0]        ic;
   } req_type;

   typedef struct packed {
      logic               status;
      logic               found;
      logic [5:0]         entry_index;
      logic signed [31:0] entry_value;
      logic [1:0]         entry_kind;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic stage;
      logic full;
      logic add_wr;
      logic count_inc;
      logic scan_issue;
      logic reloc_issue;
      logic check;
      logic wback;
      logic load_out;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic w_last;
      logic iss_last_word;
      logic iss_last_entry;
      logic chk_last_word;
      logic chk_last_entry;
      logic hit;
   } dp_status_type;

endpackage

### design/stlr_ram.sv
module stlr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/stlr_ctrl.sv
`include "symbol_table_lookup_relocate_defines.svh"

module stlr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [2:0]              req_func,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  stlr_pkg::dp_status_type stat,
   output stlr_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ADD   = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_RELOC = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rd_v_ff, rd_v_in;
   logic      issue_done_ff, issue_done_in;
   logic      scan_finish;

   assign scan_finish = (state_ff == ST_SCAN) && rd_v_ff && (stat.hit || stat.chk_last_word);

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      issue_done_in = issue_done_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept    = 1'b1;
               issue_done_in = 1'b0;
               unique case (req_func)
                  stlr_pkg::FUNC_STAGE: begin
                     cmd.stage = 1'b1;
                  end
                  stlr_pkg::FUNC_ADD: begin
                     if (stat.full) begin
                        cmd.full = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_ADD;
                     end
                  end
                  stlr_pkg::FUNC_FIND_SYM, stlr_pkg::FUNC_FIND_MAC: begin
                     state_in = stat.empty ? ST_DONE : ST_SCAN;
                  end
                  stlr_pkg::FUNC_RELOC: begin
                     if (!stat.empty) begin
                        state_in = ST_RELOC;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD: begin
            cmd.add_wr = 1'b1;
            if (stat.w_last) begin
               cmd.count_inc = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = !issue_done_ff;
            cmd.check      = rd_v_ff;
            if (cmd.scan_issue && stat.iss_last_word) begin
               issue_done_in = 1'b1;
            end
            if (scan_finish) begin
               state_in = ST_DONE;
            end
         end
         ST_RELOC: begin
            cmd.reloc_issue = !issue_done_ff;
            cmd.wback       = rd_v_ff;
            if (cmd.reloc_issue && stat.iss_last_entry) begin
               issue_done_in = 1'b1;
            end
            if (rd_v_ff && stat.chk_last_entry) begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            // hold the result until the output slot frees up
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // drop the read issued as the scan ends, since its data is not needed
   assign rd_v_in = (cmd.scan_issue && !scan_finish) || cmd.reloc_issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         rd_v_ff       <= 1'b0;
         issue_done_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rd_v_ff       <= rd_v_in;
         issue_done_ff <= issue_done_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `STLR_ASSERT_IMPL(a_no_overwrite, cmd.load_out, !(rsp_valid_ff && rsp_stall))
   `STLR_ASSERT_IMPL(a_read_in_walk, rd_v_ff, state_ff == ST_SCAN || state_ff == ST_RELOC)
   `STLR_ASSERT_NEXT(a_done_result, state_ff == ST_DONE && state_in == ST_IDLE, rsp_valid_ff)

endmodule

### design/stlr_dp.sv
`include "symbol_table_lookup_relocate_defines.svh"

module stlr_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  stlr_pkg::req_type       req_data,
   input  logic                    csr_write,
   input  logic [15:0]             csr_data,
   input  stlr_pkg::ctrl_cmd_type  cmd,
   output stlr_pkg::dp_status_type stat,
   output stlr_pkg::rsp_type       rsp_data
);

   logic [63:0]         staged_ff [stlr_pkg::NAME_WORDS];
   logic [63:0]         staged_in [stlr_pkg::NAME_WORDS];
   stlr_pkg::cnt_type   count_ff, count_in;
   logic [15:0]         offset_ff, offset_in;
   stlr_pkg::naddr_type fill_ff, fill_in;

   logic [2:0]          func_ff;
   logic [31:0]         value_ff;
   logic [1:0]          kind_ff;
   logic [15:0]         ic_ff;

   stlr_pkg::idx_type   e_ff, e_in;
   stlr_pkg::word_type  w_ff, w_in;
   stlr_pkg::naddr_type naddr_ff, naddr_in;
   stlr_pkg::idx_type   d_e_ff;
   stlr_pkg::word_type  d_w_ff;
   logic                mism_ff, mism_in;
   stlr_pkg::rsp_type   res_ff, res_in;
   stlr_pkg::rsp_type   rsp_ff, rsp_in;

   logic [63:0]         name_rd;
   logic [31:0]         value_rd;
   logic [1:0]          kind_rd;
   stlr_pkg::word_type  w_next;
   logic                w_last, d_w_last;
   logic                mism_all, kind_ok, hit;
   logic                first_word_wr;
   logic                val_wr_en;
   stlr_pkg::idx_type   val_wr_addr;
   logic [31:0]         val_wr_data;
   stlr_pkg::idx_type   add_idx;

   assign w_last   = (w_ff == stlr_pkg::WORD_LAST);
   assign d_w_last = (d_w_ff == stlr_pkg::WORD_LAST);
   assign w_next   = w_last ? '0 : w_ff + stlr_pkg::word_type'(1);
   assign add_idx  = count_ff[stlr_pkg::IDX_W-1:0];

   // name compare, one word per cycle, mismatch sticky across the entry
   assign mism_all = mism_ff || (name_rd != staged_ff[d_w_ff]);
   assign kind_ok  = (func_ff != stlr_pkg::FUNC_FIND_MAC) || (kind_rd == stlr_pkg::KIND_MACRO);
   assign hit      = d_w_last && !mism_all && kind_ok;

   always_comb begin
      staged_in = staged_ff;
      if (cmd.stage && (int'(req_data.chunk_index) < stlr_pkg::NAME_WORDS)) begin
         staged_in[stlr_pkg::word_type'(req_data.chunk_index)] = req_data.name_chunk;
      end

      count_in  = count_ff + stlr_pkg::cnt_type'(cmd.count_inc);
      offset_in = csr_write ? csr_data : offset_ff;
      fill_in   = cmd.add_wr ? fill_ff + stlr_pkg::naddr_type'(1) : fill_ff;

      e_in     = e_ff;
      w_in     = w_ff;
      naddr_in = naddr_ff;
      priority if (cmd.accept) begin
         e_in     = '0;
         w_in     = '0;
         naddr_in = '0;
      end else if (cmd.add_wr) begin
         w_in = w_next;
      end else if (cmd.scan_issue) begin
         naddr_in = naddr_ff + stlr_pkg::naddr_type'(1);
         w_in     = w_next;
         if (w_last) begin
            e_in = e_ff + stlr_pkg::idx_type'(1);
         end
      end else if (cmd.reloc_issue) begin
         e_in = e_ff + stlr_pkg::idx_type'(1);
      end

      mism_in = mism_ff;
      if (cmd.accept) begin
         mism_in = 1'b0;
      end else if (cmd.check) begin
         mism_in = d_w_last ? 1'b0 : mism_all;
      end

      res_in = res_ff;
      if (cmd.accept) begin
         res_in        = '0;
         res_in.status = cmd.full;
      end else if (cmd.check && hit) begin
         res_in.found       = 1'b1;
         res_in.entry_index = 6'(d_e_ff);
         res_in.entry_value = value_rd;
         res_in.entry_kind  = kind_rd;
      end

      rsp_in = cmd.load_out ? res_ff : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < stlr_pkg::NAME_WORDS; i++) begin
            staged_ff[i] <= '0;
         end
         count_ff  <= '0;
         offset_ff <= stlr_pkg::ADDR_OFFSET_RESET;
         fill_ff   <= '0;
      end else begin
         staged_ff <= staged_in;
         count_ff  <= count_in;
         offset_ff <= offset_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff  <= req_data.func;
         value_ff <= req_data.value;
         kind_ff  <= req_data.symbol_kind;
         ic_ff    <= req_data.ic;
      end
      e_ff     <= e_in;
      w_ff     <= w_in;
      naddr_ff <= naddr_in;
      d_e_ff   <= e_ff;
      d_w_ff   <= w_ff;
      mism_ff  <= mism_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   // value and kind go in with the first name word of an add
   assign first_word_wr = cmd.add_wr && (w_ff == '0);
   assign val_wr_en     = first_word_wr || (cmd.wback && (kind_rd == stlr_pkg::KIND_DATA));
   assign val_wr_addr   = cmd.add_wr ? add_idx : d_e_ff;
   assign val_wr_data   = cmd.add_wr ? value_ff
                                     : value_rd + 32'(offset_ff) + 32'(ic_ff);

   stlr_ram #(
      .WIDTH (64),
      .DEPTH (stlr_pkg::TABLE_DEPTH * stlr_pkg::NAME_WORDS)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (cmd.add_wr),
      .wr_addr (fill_ff),
      .wr_data (staged_ff[w_ff]),
      .rd_addr (naddr_ff),
      .rd_data (name_rd)
   );

   stlr_ram #(
      .WIDTH (32),
      .DEPTH (stlr_pkg::TABLE_DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_addr (e_ff),
      .rd_data (value_rd)
   );

   stlr_ram #(
      .WIDTH (2),
      .DEPTH (stlr_pkg::TABLE_DEPTH)
   ) u_kind_ram (
      .clock   (clock),
      .wr_en   (first_word_wr),
      .wr_addr (add_idx),
      .wr_data (kind_ff),
      .rd_addr (e_ff),
      .rd_data (kind_rd)
   );

   assign stat.full           = (count_ff >= stlr_pkg::cnt_type'(stlr_pkg::TABLE_DEPTH));
   assign stat.empty          = (count_ff == '0);
   assign stat.w_last         = w_last;
   assign stat.iss_last_entry = ((stlr_pkg::cnt_type'(e_ff) + stlr_pkg::cnt_type'(1)) == count_ff);
   assign stat.iss_last_word  = stat.iss_last_entry && w_last;
   assign stat.chk_last_entry = ((stlr_pkg::cnt_type'(d_e_ff) + stlr_pkg::cnt_type'(1))
                                 == count_ff);
   assign stat.chk_last_word  = stat.chk_last_entry && d_w_last;
   assign stat.hit            = hit;

   assign rsp_data = rsp_ff;

   `STLR_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= stlr_pkg::cnt_type'(stlr_pkg::TABLE_DEPTH))
   `STLR_ASSERT_IMPL(a_add_room, cmd.add_wr, !stat.full)
   `STLR_ASSERT_NEXT(a_count_step, cmd.count_inc, count_ff == $past(count_ff) + stlr_pkg::cnt_type'(1))

endmodule

### design/symbol_table_lookup_relocate.sv
// Fixed-capacity assembler symbol table. Names of up to NAME_WORDS 64-bit chunks are staged
// with one beat each. An add writes the staged name into the name memory one word per cycle;
// when the table is full it writes nothing and its result reports the full status.
// A find streams the name memory one word per cycle and stops early when it hits. A relocate
// reads and writes back one entry per cycle and gives no result beat. The single read port
// of the name memory sets the find time. One request is worked on at a time; a finished
// result waits in an output register so the next request is taken meanwhile. The relocation
// base is written through the csr port and resets to 100; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module symbol_table_lookup_relocate (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stlr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stlr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   stlr_pkg::ctrl_cmd_type  cmd;
   stlr_pkg::dp_status_type stat;

   assign csr_ready = 1'b1;

   stlr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   stlr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

### test/symbol_table_checker.sv
module symbol_table_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  stlr_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  stlr_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [15:0]       csr_data,
   output int                mismatch_count,
   output int                pending_count,
   output int                reply_count,
   output int                hit_count,
   output int                miss_count,
   output int                full_count,
   output int                reloc_count
);

   logic [63:0]       staged [stlr_pkg::NAME_WORDS];
   logic [63:0]       names [stlr_pkg::TABLE_DEPTH][stlr_pkg::NAME_WORDS];
   logic [31:0]       values [stlr_pkg::TABLE_DEPTH];
   logic [1:0]        kinds [stlr_pkg::TABLE_DEPTH];
   int                entries;
   logic [15:0]       offset;
   stlr_pkg::rsp_type owed_replies [$];

   // Apply one request to the shadow table; return 1 when it produces a reply.
   function automatic bit update_symbol_table(input stlr_pkg::req_type r,
                                              output stlr_pkg::rsp_type reply);
      bit hit;
      bit same;
      int i;
      int w;
      reply = '0;
      unique case (r.func)
         stlr_pkg::FUNC_STAGE: begin
            if (int'(r.chunk_index) < stlr_pkg::NAME_WORDS)
               staged[r.chunk_index] = r.name_chunk;
            return 1'b0;
         end
         stlr_pkg::FUNC_ADD: begin
            if (entries >= stlr_pkg::TABLE_DEPTH) begin
               reply.status = 1'b1;
               full_count++;
            end else begin
               for (w = 0; w < stlr_pkg::NAME_WORDS; w++)
                  names[entries][w] = staged[w];
               values[entries] = r.value;
               kinds[entries]  = r.symbol_kind;
               entries++;
            end
            return 1'b1;
         end
         stlr_pkg::FUNC_FIND_SYM, stlr_pkg::FUNC_FIND_MAC: begin
            hit = 1'b0;
            for (i = 0; i < entries && !hit; i++) begin
               same = 1'b1;
               for (w = 0; w < stlr_pkg::NAME_WORDS; w++)
                  if (names[i][w] !== staged[w])
                     same = 1'b0;
               if (same && (r.func != stlr_pkg::FUNC_FIND_MAC ||
                            kinds[i] == stlr_pkg::KIND_MACRO)) begin
                  hit               = 1'b1;
                  reply.found       = 1'b1;
                  reply.entry_index = 6'(i);
                  reply.entry_value = values[i];
                  reply.entry_kind  = kinds[i];
               end
            end
            if (hit)
               hit_count++;
            else
               miss_count++;
            return 1'b1;
         end
         stlr_pkg::FUNC_RELOC: begin
            // wrap modulo 2^32
            for (i = 0; i < entries; i++)
               if (kinds[i] == stlr_pkg::KIND_DATA)
                  values[i] = values[i] + 32'(offset) + 32'(r.ic);
            reloc_count++;
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: reply %0d %s mismatch: expected %h, actual %h",
                  $time, reply_count, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      stlr_pkg::rsp_type want;
      stlr_pkg::rsp_type reply;
      if (reset) begin
         entries = 0;
         offset  = stlr_pkg::ADDR_OFFSET_RESET;
         for (int w = 0; w < stlr_pkg::NAME_WORDS; w++)
            staged[w] = '0;
         owed_replies.delete();
         mismatch_count = 0;
         reply_count    = 0;
         hit_count      = 0;
         miss_count     = 0;
         full_count     = 0;
         reloc_count    = 0;
      end else begin
         if (csr_valid && csr_ready)
            offset = csr_data;
         if (rsp_valid && !rsp_stall) begin
            reply_count++;
            if (owed_replies.size() == 0) begin
               $display("%0t: unexpected reply beat: expected none, actual %h",
                        $time, rsp_data);
               mismatch_count++;
            end else begin
               want = owed_replies.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("found", 32'(want.found), 32'(rsp_data.found));
               check_field("entry_index", 32'(want.entry_index), 32'(rsp_data.entry_index));
               check_field("entry_value", want.entry_value, rsp_data.entry_value);
               check_field("entry_kind", 32'(want.entry_kind), 32'(rsp_data.entry_kind));
            end
         end
         if (req_valid && !req_stall)
            if (update_symbol_table(req_data, reply))
               owed_replies.push_back(reply);
      end
      pending_count <= owed_replies.size();
   end

endmodule

### test/tb.sv
module tb;

   localparam int          POOL_SIZE     = 20;
   localparam int          PHASE_ITEMS   = 425;
   localparam int          SETTLE_CYCLES = 100;
   localparam int          HOLD_CYCLES   = 1500;
   localparam int          QUIET_ITEMS   = 250;
   localparam logic [2:0]  FUNC_UNUSED   = 3'd5;
   localparam logic [1:0]  KIND_OTHER    = 2'd3;

   typedef logic [stlr_pkg::NAME_WORDS-1:0][63:0] name_words_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   stlr_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   stlr_pkg::rsp_type rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [15:0]       csr_data;

   int mismatch_count;
   int pending_count;
   int reply_count;
   int hit_count;
   int miss_count;
   int full_count;
   int reloc_count;

   int             items_sent = 0;
   bit             quiet = 1'b0;
   bit             hold_off = 1'b0;
   bit             held = 1'b0;
   name_words_type pool [POOL_SIZE];

   symbol_table_lookup_relocate DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   symbol_table_checker table_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .reply_count    (reply_count),
      .hit_count      (hit_count),
      .miss_count     (miss_count),
      .full_count     (full_count),
      .reloc_count    (reloc_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #36_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic stlr_pkg::req_type random_request(input logic [2:0] code);
      stlr_pkg::req_type r;
      r.func        = code;
      r.name_chunk  = {$urandom, $urandom};
      r.chunk_index = 2'($urandom);
      r.value       = $urandom;
      r.symbol_kind = 2'($urandom);
      r.ic          = 16'($urandom);
      if ($urandom_range(7) == 0)
         r.ic = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      return r;
   endfunction

   function automatic stlr_pkg::req_type random_op();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30)
         return random_request(stlr_pkg::FUNC_ADD);
      else if (pick < 65)
         return random_request(stlr_pkg::FUNC_FIND_SYM);
      else if (pick < 90)
         return random_request(stlr_pkg::FUNC_FIND_MAC);
      return random_request(stlr_pkg::FUNC_RELOC);
   endfunction

   function automatic name_words_type make_name(input int slot);
      name_words_type name;
      int len;
      int b;
      name = '0;
      if (slot == 1) begin
         name = '1;
      end else if (slot % 5 == 2) begin
         // junk after the terminator still counts in the compare
         for (b = 0; b < stlr_pkg::NAME_WORDS; b++)
            name[b] = {$urandom, $urandom};
      end else if (slot % 5 == 3) begin
         name = pool[slot-1];
         name[stlr_pkg::NAME_WORDS-1][63 - $urandom_range(7)] ^= 1'b1;
      end else if (slot != 0) begin
         len = $urandom_range(1, stlr_pkg::NAME_WORDS * 8);
         for (b = 0; b < len; b++)
            name[b/8][(b%8)*8 +: 8] = 8'($urandom_range(1, 255));
      end
      return name;
   endfunction

   task automatic push_request(input stlr_pkg::req_type item);
      while (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (item.func <= stlr_pkg::FUNC_RELOC)
         items_sent++;
   endtask

   task automatic stage_name(input name_words_type name);
      stlr_pkg::req_type r;
      int first;
      int k;
      first = $urandom_range(stlr_pkg::NAME_WORDS - 1);
      for (k = 0; k < stlr_pkg::NAME_WORDS; k++) begin
         r = random_request(stlr_pkg::FUNC_STAGE);
         r.chunk_index = 2'((first + k) % stlr_pkg::NAME_WORDS);
         r.name_chunk  = name[(first + k) % stlr_pkg::NAME_WORDS];
         push_request(r);
      end
   endtask

   // Drain all replies, then give a trailing relocate time to finish.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(input logic [15:0] setting);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= setting;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(input bit with_hold, input bit with_quiet);
      int start;
      int pick;
      stlr_pkg::req_type r;
      start = items_sent;
      quiet = with_quiet;
      while (items_sent < start + PHASE_ITEMS) begin
         if (with_hold && items_sent > start + 100)
            hold_off = 1'b1;
         if (with_quiet && items_sent > start + QUIET_ITEMS)
            quiet = 1'b0;
         pick = $urandom_range(99);
         if (pick < 70) begin
            stage_name(pool[$urandom_range(POOL_SIZE - 1)]);
            repeat ($urandom_range(1, 3)) push_request(random_op());
         end else if (pick < 85) begin
            // overwrite one chunk of whatever is staged
            push_request(random_request(stlr_pkg::FUNC_STAGE));
            push_request(random_op());
         end else if (pick < 90) begin
            r = random_request(FUNC_UNUSED + 3'($urandom_range(2)));
            push_request(r);
         end else begin
            push_request(random_op());
         end
      end
      quiet = 1'b0;
   endtask

   // Receiver side: random stalls plus one long hold-off to back up the block.
   initial begin : receiver
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            for (n = 0; n < HOLD_CYCLES; n++)
               @(posedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 8);
         end
      end
   end

   initial begin : stimulus
      stlr_pkg::req_type r;
      name_words_type    name_a;
      int                i;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      for (i = 0; i < POOL_SIZE; i++)
         pool[i] = make_name(i);
      name_a    = '0;
      name_a[0] = '1;
      name_a[1] = 64'h0000_6261_7a7a_6966;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, first match, macro filter, relocation wrap.
      push_request(random_request(stlr_pkg::FUNC_FIND_SYM));
      push_request(random_request(stlr_pkg::FUNC_FIND_MAC));
      r = random_request(stlr_pkg::FUNC_ADD);
      r.value       = 32'sh8000_0000;
      r.symbol_kind = stlr_pkg::KIND_DATA;
      push_request(r);
      stage_name(name_a);
      r = random_request(stlr_pkg::FUNC_ADD);
      r.value       = 32'sh7FFF_FFFF;
      r.symbol_kind = stlr_pkg::KIND_MACRO;
      push_request(r);
      r = random_request(stlr_pkg::FUNC_ADD);
      r.value       = -32'sd1;
      r.symbol_kind = stlr_pkg::KIND_DATA;
      push_request(r);
      push_request(random_request(stlr_pkg::FUNC_FIND_SYM));
      push_request(random_request(stlr_pkg::FUNC_FIND_MAC));
      r = random_request(stlr_pkg::FUNC_STAGE);
      r.chunk_index = 2'd2;
      r.name_chunk  = ~name_a[2];
      push_request(r);
      push_request(random_request(stlr_pkg::FUNC_FIND_SYM));
      r = random_request(stlr_pkg::FUNC_ADD);
      r.symbol_kind = KIND_OTHER;
      push_request(r);
      push_request(random_request(stlr_pkg::FUNC_FIND_MAC));
      r = random_request(stlr_pkg::FUNC_RELOC);
      r.ic = 16'hFFFF;
      push_request(r);
      r = random_request(stlr_pkg::FUNC_RELOC);
      r.ic = 16'h0000;
      push_request(r);
      push_request(random_request(stlr_pkg::FUNC_FIND_SYM));
      stage_name('0);
      push_request(random_request(stlr_pkg::FUNC_FIND_SYM));
      for (i = 0; i < 3; i++)
         push_request(random_request(FUNC_UNUSED + 3'(i)));

      write_offset(16'hFFFF);
      run_random_phase(1'b1, 1'b0);
      write_offset(16'h0000);
      run_random_phase(1'b0, 1'b1);
      write_offset(16'($urandom));
      run_random_phase(1'b0, 1'b0);
      write_offset(16'($urandom));
      run_random_phase(1'b0, 1'b0);
      settle();

      $display("Ran %0d requests over five offset settings, %0d replies checked.",
               items_sent, reply_count);
      $display("Finds: %0d hit, %0d missed; %0d adds refused when full; %0d relocations.",
               hit_count, miss_count, full_count, reloc_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
